// File: hdl/pia_port_interface_assert.svh
// Assertion macros for the parallel interface adapter.
// Used by pia_port_interface.sv; compiled out when SYNTHESIS is defined.
`ifndef PIA_PORT_INTERFACE_ASSERT_SVH
`define PIA_PORT_INTERFACE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define PIA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pia_port_interface: assertion failed");
// Check a property on every rising edge, reset included.
`define PIA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pia_port_interface: assertion failed");
`else
`define PIA_ASSERT(lbl, clk, rst, prop)
`define PIA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/pia_pkg.sv
// Types and constants shared by the parallel interface adapter modules.
// No dependencies.
`default_nettype none
package pia_pkg;

  // Item kinds
  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_VSYNC     = 3'd2;
  localparam logic [2:0] OP_LIGHT_PEN = 3'd3;
  localparam logic [2:0] OP_VSYNC_ACK = 3'd4;

  // Register select
  localparam logic [1:0] REG_PORT_A = 2'd0;
  localparam logic [1:0] REG_CTRL_A = 2'd1;
  localparam logic [1:0] REG_PORT_B = 2'd2;
  localparam logic [1:0] REG_CTRL_B = 2'd3;

  // Control register bits
  localparam int CTL_EN1      = 0;
  localparam int CTL_DATA_SEL = 2;
  localparam int CTL_EN2      = 3;

  // Flag bits
  localparam int FLAG_A1 = 0;
  localparam int FLAG_A2 = 1;
  localparam int FLAG_B1 = 2;
  localparam int FLAG_B2 = 3;

  localparam int CTL_W    = 6;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic       key_bit;
    logic       cassette_playing;
    logic       cassette_level;
    logic       cassette_recording;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       firq_line;
    logic [6:0] scan_code;
    logic       buzzer_strobe;
    logic       buzzer_bit;
    logic       tape_strobe;
    logic       tape_bit;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/pia_in_stage.sv
// Input register of the parallel interface adapter: unpacks and holds one transfer.
// Depends on pia_pkg.
`default_nettype none
module pia_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_valid,
  output logic                                 s_ready,
  input  wire logic [pia_pkg::IN_DATA_W-1:0]   s_data,
  input  wire logic [pia_pkg::IN_USER_W-1:0]   s_user,
  input  wire logic                            advance,
  output logic                                 item_valid,
  output pia_pkg::item_t                       item
);

  // Take a new transfer when empty or when the held item moves on
  assign s_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  // Unpack payload
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item.opcode             <= s_user[2:0];
      item.reg_index          <= s_user[4:3];
      item.write_data         <= s_data[7:0];
      item.key_bit            <= s_data[8];
      item.cassette_playing   <= s_data[9];
      item.cassette_level     <= s_data[10];
      item.cassette_recording <= s_data[11];
    end
  end

endmodule
`default_nettype wire

// File: hdl/pia_core.sv
// Register file and access logic of the parallel interface adapter.
// Depends on pia_pkg.
`default_nettype none
module pia_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire pia_pkg::item_t  item,
  output pia_pkg::result_t     result
);

  logic [pia_pkg::CTL_W-1:0] control_a, control_a_next;
  logic [pia_pkg::CTL_W-1:0] control_b, control_b_next;
  logic [7:0] direction_a, direction_a_next;
  logic [7:0] direction_b, direction_b_next;
  logic [7:0] latch_a, latch_a_next;
  logic [6:0] latch_b, latch_b_next;
  logic       pin_a_high, pin_a_high_next;
  logic [3:0] flags, flags_next;

  // Decode the access and work out the next state
  always_comb begin
    control_a_next   = control_a;
    control_b_next   = control_b;
    direction_a_next = direction_a;
    direction_b_next = direction_b;
    latch_a_next     = latch_a;
    latch_b_next     = latch_b;
    pin_a_high_next  = pin_a_high;
    flags_next       = flags;
    result           = '0;

    unique case (item.opcode)
      pia_pkg::OP_READ: begin
        unique case (item.reg_index)
          pia_pkg::REG_PORT_A: begin
            if (control_a[pia_pkg::CTL_DATA_SEL]) begin
              if (item.cassette_playing) begin
                pin_a_high_next = item.cassette_level;
              end
              result.read_data = (latch_a & direction_a) |
                                 ({pin_a_high_next, 7'b0} & ~direction_a);
              flags_next[pia_pkg::FLAG_A1] = 1'b0;
              flags_next[pia_pkg::FLAG_A2] = 1'b0;
            end else begin
              result.read_data = direction_a;
            end
          end
          pia_pkg::REG_CTRL_A: begin
            result.read_data = {flags[pia_pkg::FLAG_A1], flags[pia_pkg::FLAG_A2], control_a};
          end
          pia_pkg::REG_PORT_B: begin
            if (control_b[pia_pkg::CTL_DATA_SEL]) begin
              result.read_data = {item.key_bit, latch_b};
              flags_next[pia_pkg::FLAG_B1] = 1'b0;
              flags_next[pia_pkg::FLAG_B2] = 1'b0;
            end else begin
              result.read_data = direction_b;
            end
          end
          pia_pkg::REG_CTRL_B: begin
            result.read_data = {flags[pia_pkg::FLAG_B1], flags[pia_pkg::FLAG_B2], control_b};
          end
          default: ;
        endcase
      end
      pia_pkg::OP_WRITE: begin
        unique case (item.reg_index)
          pia_pkg::REG_PORT_A: begin
            if (control_a[pia_pkg::CTL_DATA_SEL]) begin
              latch_a_next = item.write_data;
              if (item.cassette_recording) begin
                result.tape_strobe = 1'b1;
                result.tape_bit    = item.write_data[0];
              end
            end else begin
              direction_a_next = item.write_data;
            end
          end
          pia_pkg::REG_CTRL_A: begin
            control_a_next = item.write_data[pia_pkg::CTL_W-1:0];
          end
          pia_pkg::REG_PORT_B: begin
            if (control_b[pia_pkg::CTL_DATA_SEL]) begin
              latch_b_next         = item.write_data[6:0];
              result.buzzer_strobe = 1'b1;
              result.buzzer_bit    = item.write_data[0];
            end else begin
              direction_b_next = item.write_data;
            end
          end
          pia_pkg::REG_CTRL_B: begin
            control_b_next = item.write_data[pia_pkg::CTL_W-1:0];
          end
          default: ;
        endcase
      end
      pia_pkg::OP_VSYNC:     flags_next[pia_pkg::FLAG_B1] = 1'b1;
      pia_pkg::OP_LIGHT_PEN: flags_next[pia_pkg::FLAG_A1] = 1'b1;
      pia_pkg::OP_VSYNC_ACK: flags_next[pia_pkg::FLAG_B1] = 1'b0;
      default: ;
    endcase

    // Interrupt lines follow the state after the access
    result.irq_line  = (flags_next[pia_pkg::FLAG_A1] & control_a_next[pia_pkg::CTL_EN1]) |
                       (flags_next[pia_pkg::FLAG_A2] & control_a_next[pia_pkg::CTL_EN2]);
    result.firq_line = (flags_next[pia_pkg::FLAG_B1] & control_b_next[pia_pkg::CTL_EN1]) |
                       (flags_next[pia_pkg::FLAG_B2] & control_b_next[pia_pkg::CTL_EN2]);
    result.scan_code = latch_b_next;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      control_a   <= '0;
      control_b   <= '0;
      direction_a <= '0;
      direction_b <= '0;
      latch_a     <= '0;
      latch_b     <= '0;
      pin_a_high  <= 1'b0;
      flags       <= '0;
    end else if (advance) begin
      control_a   <= control_a_next;
      control_b   <= control_b_next;
      direction_a <= direction_a_next;
      direction_b <= direction_b_next;
      latch_a     <= latch_a_next;
      latch_b     <= latch_b_next;
      pin_a_high  <= pin_a_high_next;
      flags       <= flags_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/pia_out_stage.sv
// Result register of the parallel interface adapter: holds and packs one result.
// Depends on pia_pkg.
`default_nettype none
module pia_out_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire pia_pkg::result_t                result,
  output logic                                 m_valid,
  input  wire logic                            m_ready,
  output logic [pia_pkg::OUT_DATA_W-1:0]       m_data
);

  // Load on advance, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  // Pack the result fields, lowest first
  always_ff @(posedge clk) begin
    if (advance) begin
      m_data <= {3'b0, result.tape_bit, result.tape_strobe, result.buzzer_bit,
                 result.buzzer_strobe, result.scan_code, result.firq_line,
                 result.irq_line, result.read_data};
    end
  end

endmodule
`default_nettype wire

// File: hdl/pia_port_interface.sv
// Top level of the two-port parallel interface adapter.
// Depends on pia_pkg, pia_in_stage, pia_core, pia_out_stage and the assertion header.
//
//   channel   dir   handshake                       payload
//   s_axis    in    s_axis_tvalid / s_axis_tready   tdata 16 bits, tuser 5 bits
//   m_axis    out   m_axis_tvalid / m_axis_tready   tdata 24 bits
//
// One access or event per cycle while m_axis is not stalled. Each result passes
// through the input register and the result register before it is valid on m_axis.
// The register update and the result are formed combinationally between the input
// register and the result register.
// Reset clears the core's registers and flags and both valid bits.
// A stalled m_axis holds the result, then the input register fills and s_axis_tready
// drops until the result transfer frees them.
`default_nettype none
`include "pia_port_interface_assert.svh"
module pia_port_interface (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] write_data, [8] key_bit, [9] cassette_playing, [10] cassette_level,
  // [11] cassette_recording, [15:12] zero
  input  wire logic [pia_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] opcode, [4:3] reg_index
  input  wire logic [pia_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] read_data, [8] irq_line, [9] firq_line, [16:10] scan_code,
  // [17] buzzer_strobe, [18] buzzer_bit, [19] tape_strobe, [20] tape_bit, [23:21] zero
  output logic [pia_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

  logic             item_valid;
  logic             advance;
  pia_pkg::item_t   item;
  pia_pkg::result_t result;

  // Move the held item on when the result register is free or draining
  assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

  pia_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_data     (s_axis_tdata),
    .s_user     (s_axis_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pia_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  pia_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .result  (result),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata)
  );

  // Checks
  `PIA_ASSERT(a_advance_fills_out, clk, rst, advance |=> m_axis_tvalid)
  `PIA_ASSERT(a_no_overwrite, clk, rst, (s_axis_tready && item_valid) |-> advance)
  `PIA_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!m_axis_tvalid && !item_valid))
  `PIA_ASSERT(a_buzzer_bit, clk, rst, advance |-> (result.buzzer_strobe || !result.buzzer_bit))
  `PIA_ASSERT(a_tape_bit, clk, rst, advance |-> (result.tape_strobe || !result.tape_bit))

endmodule
`default_nettype wire
